/* src/opl_pkg.sv */
package opl_pkg;

  localparam int GainW = 25;
  localparam int CoefW = 25;
  localparam int ThrW = 21;
  localparam int OutW = 22;
  localparam int DbW = 16;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 25;
  localparam int QuoW = 24;
  localparam int LogSteps = 16;

  localparam logic [GainW-1:0] GainOne = 25'd16777216;
  localparam logic [GainW-1:0] GainNearOne = 25'd16777200;
  localparam logic [GainW-1:0] GainTiny = 25'd16;
  localparam logic [18:0] DbK = 19'd394566;
  localparam logic [DbW-1:0] DbFloorMag = 16'd30720;

  localparam logic [ThrW-1:0] ThrRst = 21'd933254;
  localparam logic [CoefW-1:0] AtkRst = 25'd345960;
  localparam logic [CoefW-1:0] RelRst = 25'd4369;

  typedef enum logic [CfgAddrW-1:0] {
    REG_ENABLE = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_ATTACK = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic step_mul;
    logic upd;
    logic out_mul;
    logic log_init;
    logic log_step;
    logic db_mul;
    logic fin;
  } opl_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } opl_stat_t;

endpackage

/* src/opl_ctrl.sv */
module opl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  opl_pkg::opl_stat_t stat,
  output opl_pkg::opl_cmd_t  cmd
);
  import opl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_STEP, S_UPD, S_OMUL, S_LNORM, S_LOG, S_DBMUL, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          cmd.load = 1'b1;
          state_nxt = stat.bypass ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QuoW - 1)) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step_mul = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = S_OMUL;
      end
      S_OMUL: begin
        cmd.out_mul = 1'b1;
        state_nxt = S_LNORM;
      end
      S_LNORM: begin
        cmd.log_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LogSteps - 1)) begin
          state_nxt = S_DBMUL;
        end
      end
      S_DBMUL: begin
        cmd.db_mul = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_log_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOG |-> cnt_r < 5'(LogSteps)) else $error("log count overrun");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < 5'(QuoW)) else $error("div count overrun");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> stat.out_free) else $error("result dropped");
`endif
endmodule

/* src/opl_dp.sv */
module opl_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  opl_pkg::opl_cmd_t               cmd,
  output opl_pkg::opl_stat_t              stat,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  input  logic                            in_sample_invalid,
  input  logic                            en,
  input  logic [opl_pkg::ThrW-1:0]        thr,
  input  logic [opl_pkg::CoefW-1:0]       atk,
  input  logic [opl_pkg::CoefW-1:0]       rel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [opl_pkg::OutW-1:0] out_sample_out,
  output logic signed [opl_pkg::DbW-1:0]  out_reduction_db
);
  import opl_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CmpW = (SW > ThrW) ? SW : ThrW;
  localparam logic [SW-1:0] SampleOne = SW'(1) << (SW - 4);

  logic [SW-1:0] ax_r, rem_r;
  logic neg_r, inv_r, big_r, byp_r;
  logic [QuoW-1:0] q_r;
  logic [GainW-1:0] gain_r;
  logic [2*GainW-1:0] pc_r;
  logic fall_r;
  logic [SW+GainW-1:0] op_r;
  logic [SW-1:0] ymag_r;
  logic [31:0] m_r;
  logic [4:0] p_r;
  logic [LogSteps-1:0] frac_r;
  logic unity_r, floor_r;
  logic [39:0] dbp_r;
  logic out_valid_r;
  logic signed [OutW-1:0] out_s_r;
  logic signed [DbW-1:0] out_db_r;

  logic [SW-1:0] ax_in;
  logic [SW:0] rem2;
  logic [GainW-1:0] target, diff, coef;
  logic [2*GainW:0] stp_sum;
  logic signed [2*GainW+1:0] g_new;
  logic [SW+GainW-1:0] rnd;
  logic [SW-1:0] psat, axsat;
  logic [4:0] p_c;
  logic [63:0] sq;
  logic [32:0] sq_sh;
  logic [20:0] mag;
  logic [15:0] dbv;
  logic signed [SW:0] ysig;

  assign ax_in = in_sample_in[SW-1] ? SW'(-in_sample_in) : SW'(in_sample_in);
  assign stat.bypass = in_sample_invalid || !en;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign rem2 = {rem_r, 1'b0};
  assign target = big_r ? {1'b0, q_r} : GainOne;
  assign diff = (target < gain_r) ? gain_r - target : target - gain_r;
  assign coef = (target < gain_r) ? atk : rel;
  assign stp_sum = (2*GainW+1)'(pc_r) + (2*GainW+1)'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  always_comb begin
    g_new = fall_r ? (2*GainW+2)'(gain_r) - (2*GainW+2)'(stp_sum >> COEF_FRAC_BITS)
                   : (2*GainW+2)'(gain_r) + (2*GainW+2)'(stp_sum >> COEF_FRAC_BITS);
  end

  assign rnd = op_r + (SW+GainW)'(1 << 23);
  assign psat = ((rnd >> 24) > (SW+GainW)'(SampleOne)) ? SampleOne : SW'(rnd >> 24);
  assign axsat = (ax_r > SampleOne) ? SampleOne : ax_r;

  always_comb begin
    p_c = 5'd4;
    for (int i = 5; i < 24; i++) begin
      if (gain_r[i]) p_c = 5'(i);
    end
  end

  assign sq = m_r * m_r;
  assign sq_sh = sq[62:30];
  assign mag = (21'(5'd24 - p_r) << 16) - 21'(frac_r);
  assign dbv = ((dbp_r + 40'(1 << 23)) >> 24) > 40'(DbFloorMag) ? DbFloorMag
             : 16'((dbp_r + 40'(1 << 23)) >> 24);

  always_comb begin
    ysig = neg_r ? -$signed({1'b0, (byp_r ? axsat : ymag_r)})
                 : $signed({1'b0, (byp_r ? axsat : ymag_r)});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= ax_in;
      neg_r <= in_sample_in[SW-1];
      inv_r <= in_sample_invalid;
      byp_r <= !en;
      big_r <= CmpW'(ax_in) > CmpW'(thr);
      rem_r <= SW'(thr);
      q_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, ax_r}) begin
        rem_r <= SW'(rem2 - {1'b0, ax_r});
        q_r <= {q_r[QuoW-2:0], 1'b1};
      end else begin
        rem_r <= rem2[SW-1:0];
        q_r <= {q_r[QuoW-2:0], 1'b0};
      end
    end
    if (cmd.step_mul) begin
      pc_r <= diff * coef;
      fall_r <= target < gain_r;
    end
    if (cmd.out_mul) op_r <= ax_r * gain_r;
    if (cmd.log_init) begin
      ymag_r <= psat;
      p_r <= p_c;
      m_r <= {7'd0, gain_r} << (5'd30 - p_c);
      frac_r <= '0;
      unity_r <= gain_r >= GainNearOne;
      floor_r <= gain_r <= GainTiny;
    end
    if (cmd.log_step) begin
      if (sq_sh >= 33'h080000000) begin
        m_r <= sq_sh[32:1];
        frac_r <= {frac_r[LogSteps-2:0], 1'b1};
      end else begin
        m_r <= sq_sh[31:0];
        frac_r <= {frac_r[LogSteps-2:0], 1'b0};
      end
    end
    if (cmd.db_mul) dbp_r <= mag * DbK;
    if (cmd.fin) begin
      if (inv_r) begin
        out_s_r <= '0;
        out_db_r <= '0;
      end else if (byp_r) begin
        out_s_r <= OutW'(ysig);
        out_db_r <= '0;
      end else begin
        out_s_r <= OutW'(ysig);
        out_db_r <= unity_r ? '0 : floor_r ? -$signed(DbFloorMag) : -$signed(dbv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GainOne;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (g_new < 0) gain_r <= '0;
        else if (g_new > (2*GainW+2)'(GainOne)) gain_r <= GainOne;
        else gain_r <= GainW'(g_new);
      end
      if (cmd.fin && (inv_r || byp_r)) gain_r <= GainOne;
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_s_r;
  assign out_reduction_db = out_db_r;

`ifndef SYNTH
  a_gain_rng: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GainOne) else $error("gain out of range");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r) else $error("result not presented");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping commands");
`endif
endmodule

/* src/output_peak_limiter_top.sv */
// Limited samples pass through a restoring divider (24 quotient bits), a squaring
// log unit (16 fraction bits) and six further steps: step, update, output multiply,
// log normalise, dB multiply and finish. Invalid or bypassed samples go straight to
// finish. A stalled output holds the result in finish. The input stalls while busy,
// so a new sample is taken only after the previous result has been handed on.
// Reset (rst_n low, synchronous): gain unity, registers at defaults, output empty.
module output_peak_limiter_top #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  input  logic                                in_sample_invalid,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [opl_pkg::OutW-1:0]     out_sample_out,
  output logic signed [opl_pkg::DbW-1:0]      out_reduction_db,
  input  logic                                cfg_we,
  input  logic [opl_pkg::CfgAddrW-1:0]        cfg_addr,
  input  logic [opl_pkg::CfgDataW-1:0]        cfg_wdata
);
  import opl_pkg::*;

  logic en_r;
  logic [ThrW-1:0] thr_r;
  logic [CoefW-1:0] atk_r, rel_r;
  opl_cmd_t cmd;
  opl_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      thr_r <= ThrRst;
      atk_r <= AtkRst;
      rel_r <= RelRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ENABLE: en_r <= cfg_wdata[0];
        REG_THRESHOLD: thr_r <= cfg_wdata[ThrW-1:0];
        REG_ATTACK: atk_r <= cfg_wdata;
        REG_RELEASE: rel_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  opl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  opl_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_sample_in(in_sample_in), .in_sample_invalid(in_sample_invalid),
    .en(en_r), .thr(thr_r), .atk(atk_r), .rel(rel_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_reduction_db(out_reduction_db)
  );
endmodule
